### src/cmt_pkg.sv
`timescale 1ns / 1ps

package cmt_pkg;

   localparam int ENTRIES        = 64;
   localparam int KEY_WIDTH      = 32;
   localparam int COUNT_WIDTH    = 16;
   localparam int IDX_WIDTH      = $clog2(ENTRIES);
   localparam int ENTRY_WIDTH    = KEY_WIDTH + COUNT_WIDTH;
   localparam int OP_WIDTH       = 2;
   localparam int TOTAL_WIDTH    = 22;
   localparam int DISTINCT_WIDTH = 7;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [IDX_WIDTH-1:0]   LAST_IDX  = IDX_WIDTH'(ENTRIES - 1);

   typedef enum logic [OP_WIDTH-1:0] {
      OP_INSERT    = 2'd0,
      OP_ERASE_ONE = 2'd1,
      OP_ERASE_ALL = 2'd2,
      OP_QUERY     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_COMMIT
   } state_type;

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic                 clear;
      logic                 valid;
      logic [IDX_WIDTH-1:0] idx;
      logic                 live;
   } scan_ctrl_type;

   // what the scan found so far
   typedef struct packed {
      logic                   hit;
      logic [IDX_WIDTH-1:0]   hit_idx;
      logic [COUNT_WIDTH-1:0] hit_count;
      logic                   free;
      logic [IDX_WIDTH-1:0]   free_idx;
   } scan_result_type;

endpackage

### src/counted_multiset_table_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// req       in   req_valid/req_ready  req_op[1:0], req_key[31:0]
// rsp       out  rsp_valid/rsp_ready  rsp_ok, rsp_result_count[15:0], rsp_total_items[21:0],
//                                     rsp_distinct_items[6:0], rsp_is_empty
//
// Each request passes through accept, one read per entry from the single-port entry RAM,
// a last compare and a commit.
// Only one request is in flight; req_ready is high while the sequencer is idle.
// Reset (synchronous) clears the live bits, totals, sequencer and response valid;
// entry RAM contents are not cleared, a live bit per entry masks them.
// A response waiting on rsp_ready does not block the next request, but that
// request's commit waits until the response slot is free.

module counted_multiset_table_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [cmt_pkg::OP_WIDTH-1:0]         req_op,
   input  logic [31:0]                          req_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_ok,
   output logic [15:0]                          rsp_result_count,
   output logic [cmt_pkg::TOTAL_WIDTH-1:0]      rsp_total_items,
   output logic [cmt_pkg::DISTINCT_WIDTH-1:0]   rsp_distinct_items,
   output logic                                 rsp_is_empty
);

   // sequencer
   cmt_pkg::state_type state_ff, state_in;
   logic               req_fire;
   logic               commit_fire;

   // latched request
   cmt_pkg::op_type                 op_ff;
   logic [cmt_pkg::KEY_WIDTH-1:0]   key_ff;

   // scan address and the compare stage, which trails it by one register
   logic [cmt_pkg::IDX_WIDTH-1:0] scan_idx_ff, scan_idx_in;
   logic                          cmp_valid_ff, cmp_valid_in;
   logic [cmt_pkg::IDX_WIDTH-1:0] cmp_idx_ff;

   // per-entry live bits: count != 0
   logic [cmt_pkg::ENTRIES-1:0] live_ff, live_in;

   logic [cmt_pkg::TOTAL_WIDTH-1:0]    total_ff, total_in;
   logic [cmt_pkg::DISTINCT_WIDTH-1:0] distinct_ff, distinct_in;

   // RAM port
   logic                            ram_en;
   logic                            ram_we;
   logic [cmt_pkg::IDX_WIDTH-1:0]   ram_addr;
   logic [cmt_pkg::ENTRY_WIDTH-1:0] ram_wdata;
   logic [cmt_pkg::ENTRY_WIDTH-1:0] ram_rdata;

   logic                     scan_clear;
   cmt_pkg::scan_ctrl_type   scan_ctrl;
   cmt_pkg::scan_result_type scan_res;

   // commit decisions
   logic                            upd_we;
   logic [cmt_pkg::IDX_WIDTH-1:0]   upd_idx;
   logic [cmt_pkg::COUNT_WIDTH-1:0] upd_count;
   logic                            upd_live;
   logic                            upd_ok;
   logic [cmt_pkg::COUNT_WIDTH-1:0] upd_rc;

   // response register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_ok_ff;
   logic [15:0]                        rsp_rc_ff;
   logic [cmt_pkg::TOTAL_WIDTH-1:0]    rsp_total_ff;
   logic [cmt_pkg::DISTINCT_WIDTH-1:0] rsp_distinct_ff;

   assign req_fire    = req_valid && req_ready;
   assign commit_fire = (state_ff == cmt_pkg::ST_COMMIT) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cmt_pkg::ST_IDLE: begin
            if (req_valid) state_in = cmt_pkg::ST_SCAN;
         end
         cmt_pkg::ST_SCAN: begin
            if (scan_idx_ff == cmt_pkg::LAST_IDX) state_in = cmt_pkg::ST_FLUSH;
         end
         cmt_pkg::ST_FLUSH: begin
            state_in = cmt_pkg::ST_COMMIT;
         end
         cmt_pkg::ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = cmt_pkg::ST_IDLE;
         end
         default: begin
            state_in = cmt_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready    = 1'b0;
      ram_en       = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = scan_idx_ff;
      scan_clear   = 1'b0;
      cmp_valid_in = 1'b0;
      scan_idx_in  = scan_idx_ff;
      case (state_ff)
         cmt_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            scan_clear  = 1'b1;
            scan_idx_in = '0;
         end
         cmt_pkg::ST_SCAN: begin
            ram_en       = 1'b1;
            cmp_valid_in = 1'b1;
            scan_idx_in  = scan_idx_ff + 1'b1;
         end
         cmt_pkg::ST_FLUSH: begin
         end
         cmt_pkg::ST_COMMIT: begin
            ram_en   = commit_fire && upd_we;
            ram_we   = commit_fire && upd_we;
            ram_addr = upd_idx;
         end
         default: begin
         end
      endcase
   end

   // fields in order: clear, valid, idx, live
   assign scan_ctrl = {scan_clear, cmp_valid_ff, cmp_idx_ff, live_ff[cmp_idx_ff]};

   assign ram_wdata = {key_ff, upd_count};

   cmt_ram #(
      .WIDTH (cmt_pkg::ENTRY_WIDTH),
      .DEPTH (cmt_pkg::ENTRIES)
   ) u_entry_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   cmt_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (scan_ctrl),
      .key    (key_ff),
      .entry  (ram_rdata),
      .result (scan_res)
   );

   // commit: apply the op to the entry the scan found
   always_comb begin
      upd_we      = 1'b0;
      upd_idx     = scan_res.hit_idx;
      upd_count   = scan_res.hit_count;
      upd_live    = 1'b1;
      upd_ok      = 1'b0;
      upd_rc      = '0;
      total_in    = total_ff;
      distinct_in = distinct_ff;
      case (op_ff)
         cmt_pkg::OP_INSERT: begin
            if (scan_res.hit) begin
               // saturated count changes nothing
               if (scan_res.hit_count != cmt_pkg::COUNT_MAX) begin
                  upd_we    = 1'b1;
                  upd_count = scan_res.hit_count + 1'b1;
                  upd_ok    = 1'b1;
                  total_in  = total_ff + 1'b1;
               end
            end else if (scan_res.free) begin
               upd_we      = 1'b1;
               upd_idx     = scan_res.free_idx;
               upd_count   = cmt_pkg::COUNT_WIDTH'(1);
               upd_ok      = 1'b1;
               total_in    = total_ff + 1'b1;
               distinct_in = distinct_ff + 1'b1;
            end
         end
         cmt_pkg::OP_ERASE_ONE: begin
            if (scan_res.hit) begin
               upd_we    = 1'b1;
               upd_count = scan_res.hit_count - 1'b1;
               upd_live  = (upd_count != '0);
               upd_ok    = 1'b1;
               upd_rc    = cmt_pkg::COUNT_WIDTH'(1);
               total_in  = total_ff - 1'b1;
               if (!upd_live) distinct_in = distinct_ff - 1'b1;
            end
         end
         cmt_pkg::OP_ERASE_ALL: begin
            if (scan_res.hit) begin
               upd_we      = 1'b1;
               upd_count   = '0;
               upd_live    = 1'b0;
               upd_ok      = 1'b1;
               upd_rc      = scan_res.hit_count;
               total_in    = total_ff - cmt_pkg::TOTAL_WIDTH'(scan_res.hit_count);
               distinct_in = distinct_ff - 1'b1;
            end
         end
         cmt_pkg::OP_QUERY: begin
            if (scan_res.hit) begin
               upd_ok = 1'b1;
               upd_rc = scan_res.hit_count;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      live_in = live_ff;
      if (commit_fire && upd_we) live_in[upd_idx] = upd_live;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_fire)    rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmt_pkg::ST_IDLE;
         scan_idx_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         live_ff      <= '0;
         total_ff     <= '0;
         distinct_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit_fire) begin
            total_ff    <= total_in;
            distinct_ff <= distinct_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_idx_ff;
      if (req_fire) begin
         op_ff  <= cmt_pkg::op_type'(req_op);
         key_ff <= req_key[cmt_pkg::KEY_WIDTH-1:0];
      end
      if (commit_fire) begin
         rsp_ok_ff       <= upd_ok;
         rsp_rc_ff       <= 16'(upd_rc);
         rsp_total_ff    <= total_in;
         rsp_distinct_ff <= distinct_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_result_count   = rsp_rc_ff;
   assign rsp_total_items    = rsp_total_ff;
   assign rsp_distinct_items = rsp_distinct_ff;
   assign rsp_is_empty       = (rsp_distinct_ff == '0);

   // distinct counter tracks the live bits
   a_distinct_matches_live: assert property (@(posedge clock) disable iff (reset)
      distinct_ff == cmt_pkg::DISTINCT_WIDTH'($countones(live_ff)))
      else $error("distinct count out of step with live bits");

   // commit holds while the previous response is not taken
   a_commit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cmt_pkg::ST_COMMIT && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == cmt_pkg::ST_COMMIT))
      else $error("commit did not wait for response slot");

   // entry RAM is written only at commit
   a_write_at_commit: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> commit_fire)
      else $error("entry write outside commit");

   // a failed request never reports a count
   a_no_count_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_rc_ff == '0))
      else $error("count reported on failed request");

endmodule

### src/cmt_ram.sv
`timescale 1ns / 1ps

module cmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/cmt_scan.sv
`timescale 1ns / 1ps

module cmt_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  cmt_pkg::scan_ctrl_type              ctrl,
   input  logic [cmt_pkg::KEY_WIDTH-1:0]       key,
   input  logic [cmt_pkg::ENTRY_WIDTH-1:0]     entry,
   output cmt_pkg::scan_result_type            result
);

   logic [cmt_pkg::KEY_WIDTH-1:0]   entry_key;
   logic [cmt_pkg::COUNT_WIDTH-1:0] entry_count;
   logic                            match;
   logic                            is_free;
   cmt_pkg::scan_result_type        res_ff;
   cmt_pkg::scan_result_type        res_in;

   assign entry_key   = entry[cmt_pkg::ENTRY_WIDTH-1:cmt_pkg::COUNT_WIDTH];
   assign entry_count = entry[cmt_pkg::COUNT_WIDTH-1:0];

   // the one comparator: live entry with equal key, or a free slot
   assign match   = ctrl.valid && ctrl.live && (entry_key == key);
   assign is_free = ctrl.valid && !ctrl.live;

   always_comb begin
      res_in = res_ff;
      if (ctrl.clear) begin
         res_in.hit  = 1'b0;
         res_in.free = 1'b0;
      end else begin
         if (match && !res_ff.hit) begin
            res_in.hit       = 1'b1;
            res_in.hit_idx   = ctrl.idx;
            res_in.hit_count = entry_count;
         end
         if (is_free && !res_ff.free) begin
            res_in.free     = 1'b1;
            res_in.free_idx = ctrl.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.hit  <= 1'b0;
         res_ff.free <= 1'b0;
      end else begin
         res_ff.hit  <= res_in.hit;
         res_ff.free <= res_in.free;
      end
      res_ff.hit_idx   <= res_in.hit_idx;
      res_ff.hit_count <= res_in.hit_count;
      res_ff.free_idx  <= res_in.free_idx;
   end

   assign result = res_ff;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the counted multiset table.
// Requests come from a queue that the initial block fills before reset
// is released. A negedge driver presents them and a posedge monitor
// predicts each accepted request and checks responses in order.
module testbench;
   import cmt_pkg::*;

   localparam int LIMIT_CYCLES = 800_000;      // several times the slowest legal run
   localparam int DRAIN_CYCLES = ENTRIES + 16; // quiet time after the last response
   localparam int LONG_HOLD    = 400;          // receiver hold-off, in cycles
   localparam int QUIET_ITEMS  = 100;          // tail of the run with no idling
   localparam int POOL_SIZE    = 80;           // more keys than entries, so the table fills
   localparam int HOT_KEYS     = 10;           // small key set for count churn
   localparam int MAX_REPORTS  = 200;          // cap on printed mismatch lines

   typedef struct {
      op_type      op;
      logic [31:0] key;
   } table_request;

   typedef struct {
      logic                      ok;
      logic [COUNT_WIDTH-1:0]    count;
      logic [TOTAL_WIDTH-1:0]    total;
      logic [DISTINCT_WIDTH-1:0] distinct;
      logic                      empty;
   } table_answer;

   // ---------------------------------------------------------------
   // clock, reset and block ports
   // ---------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_WIDTH-1:0]       req_op    = '0;
   logic [31:0]               req_key   = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_ok;
   logic [15:0]               rsp_result_count;
   logic [TOTAL_WIDTH-1:0]    rsp_total_items;
   logic [DISTINCT_WIDTH-1:0] rsp_distinct_items;
   logic                      rsp_is_empty;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   counted_multiset_table_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_key            (req_key),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_ok             (rsp_ok),
      .rsp_result_count   (rsp_result_count),
      .rsp_total_items    (rsp_total_items),
      .rsp_distinct_items (rsp_distinct_items),
      .rsp_is_empty       (rsp_is_empty)
   );

   // ---------------------------------------------------------------
   // bench state
   // ---------------------------------------------------------------
   table_request request_q[$];   // requests not yet presented
   table_answer  answer_q[$];    // predicted responses, oldest first

   // predictor's own copy of the table
   logic [KEY_WIDTH-1:0]      model_keys   [ENTRIES];
   logic [COUNT_WIDTH-1:0]    model_counts [ENTRIES];
   logic [TOTAL_WIDTH-1:0]    model_total;
   logic [DISTINCT_WIDTH-1:0] model_live;

   int   errors         = 0;
   int   cycle_count    = 0;
   int   req_accepts    = 0;
   int   total_requests = 0;
   int   quiet_from     = 1 << 30;
   int   full_inserts   = 0;
   int   absent_lookups = 0;
   int   peak_live      = 0;
   int   holds_done     = 0;
   logic req_taken      = 1'b0;   // set at the edge that accepts a request
   int   req_gap        = 0;      // sender idle cycles still to go
   int   rsp_stall      = 0;      // receiver idle cycles still to go
   int   hold_left      = 0;      // long hold-off countdown
   int   hold_seen      = 0;      // requests seen by the hold-off process
   logic quiet;

   assign quiet = (req_accepts >= quiet_from);

   // ---------------------------------------------------------------
   // predictor: one request in, the response it must produce out.
   // Only live entries match; a miss on insert claims the lowest free
   // entry. Full table and saturated count leave the state alone.
   // ---------------------------------------------------------------
   function automatic table_answer predict_table(op_type op, logic [31:0] key_in);
      table_answer          ans;
      logic [KEY_WIDTH-1:0] key;
      int                   hit;
      int                   free_slot;
      key       = key_in[KEY_WIDTH-1:0];
      hit       = -1;
      free_slot = -1;
      // walk down so both land on the lowest index
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (model_counts[i] != '0 && model_keys[i] == key) hit = i;
         if (model_counts[i] == '0) free_slot = i;
      end
      ans.ok    = 1'b0;
      ans.count = '0;
      if (op == OP_INSERT) begin
         if (hit >= 0) begin
            if (model_counts[hit] != COUNT_MAX) begin
               model_counts[hit] = model_counts[hit] + 1'b1;
               model_total       = model_total + 1'b1;
               ans.ok            = 1'b1;
            end
         end else if (free_slot >= 0) begin
            model_keys[free_slot]   = key;
            model_counts[free_slot] = 1;
            model_total             = model_total + 1'b1;
            model_live              = model_live + 1'b1;
            ans.ok                  = 1'b1;
         end else begin
            full_inserts++;
         end
      end else if (hit < 0) begin
         absent_lookups++;
      end else begin
         ans.ok = 1'b1;
         case (op)
            OP_ERASE_ONE: begin
               model_counts[hit] = model_counts[hit] - 1'b1;
               model_total       = model_total - 1'b1;
               if (model_counts[hit] == '0) model_live = model_live - 1'b1;
               ans.count = 1;
            end
            OP_ERASE_ALL: begin
               ans.count         = model_counts[hit];
               model_total       = model_total - model_counts[hit];
               model_counts[hit] = '0;
               model_live        = model_live - 1'b1;
            end
            OP_QUERY: begin
               ans.count = model_counts[hit];
            end
            default: begin
            end
         endcase
      end
      if (int'(model_live) > peak_live) peak_live = model_live;
      ans.total    = model_total;
      ans.distinct = model_live;
      ans.empty    = (model_live == '0);
      return ans;
   endfunction

   task automatic add_request(op_type op, logic [31:0] key);
      table_request r;
      r.op  = op;
      r.key = key;
      request_q.push_back(r);
   endtask

   // One round of random traffic: fill past capacity from a fresh key
   // pool, drain it (with some misses and leftovers), churn counts on a
   // few hot keys, then noise with full-range keys and random ops.
   task automatic build_round(int churn_items);
      logic [31:0] pool [POOL_SIZE];
      logic [31:0] k;
      op_type      op;
      int          r;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool[i] = $urandom;
         // near-miss keys: one bit away from the previous key
         if (i > 0 && $urandom_range(0, 7) == 0)
            pool[i] = pool[i-1] ^ (32'd1 << $urandom_range(0, 31));
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
         add_request(OP_INSERT, pool[i]);
         if ($urandom_range(0, 3) == 0)
            add_request(OP_QUERY, pool[$urandom_range(0, POOL_SIZE-1)]);
         if ($urandom_range(0, 7) == 0) add_request(OP_INSERT, pool[$urandom_range(0, i)]);
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
         r = $urandom_range(0, 9);
         if (r == 0) continue;   // leave this one live
         if (r == 1) begin
            add_request(OP_ERASE_ALL, pool[i] ^ (32'd1 << $urandom_range(0, 31)));
            continue;
         end
         if (r < 5) add_request(OP_ERASE_ONE, pool[i]);
         add_request(OP_ERASE_ALL, pool[i]);
      end
      for (int i = 0; i < churn_items; i++) begin
         r = $urandom_range(0, 99);
         k = pool[$urandom_range(0, HOT_KEYS-1)];
         if (r < 40)      op = OP_INSERT;
         else if (r < 65) op = OP_ERASE_ONE;
         else if (r < 75) op = OP_ERASE_ALL;
         else             op = OP_QUERY;
         add_request(op, k);
      end
      for (int i = 0; i < 60; i++) begin
         op = op_type'($urandom_range(0, 3));
         k  = ($urandom_range(0, 2) == 0) ? pool[$urandom_range(0, POOL_SIZE-1)] : $urandom;
         add_request(op, k);
      end
   endtask

   task automatic check_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
      end
   endtask

   // ---------------------------------------------------------------
   // request driver: changes on the falling edge, holds a request
   // until accepted, then optionally idles for a random burst.
   // Chained bursts let the next request land on any scan phase.
   // ---------------------------------------------------------------
   always @(negedge clock) begin : drive_requests
      table_request item;
      logic         holding;
      int           r;
      holding   = req_valid && !req_taken;
      req_taken = 1'b0;
      if (reset || holding) begin
         // keep what is on the bus
      end else if (req_gap != 0) begin
         req_gap--;
         req_valid <= 1'b0;
      end else if (request_q.size() != 0) begin
         item = request_q.pop_front();
         req_valid <= 1'b1;
         req_op    <= item.op;
         req_key   <= item.key;
         r = $urandom_range(0, 9);
         if (quiet || r < 5) begin
            req_gap = 0;
         end else if (r < 8) begin
            req_gap = $urandom_range(1, 6);
         end else begin
            req_gap = 0;
            repeat ($urandom_range(2, 14)) req_gap += $urandom_range(1, 6);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response side: random stall bursts, plus the long hold-off below
   always @(negedge clock) begin : drive_responses
      if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0);
      end
   end

   // Long receiver hold-off, twice in the run. The sender keeps going,
   // so one response parks, the next request's commit blocks and the
   // input side backs up.
   always @(posedge clock) begin : long_hold
      if (reset) begin
         hold_left <= 0;
         hold_seen <= 0;
      end else begin
         if (req_valid && req_ready) hold_seen <= hold_seen + 1;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (req_valid && req_ready && (hold_seen == 150 || hold_seen == 600)) begin
            hold_left  <= LONG_HOLD;
            holds_done <= holds_done + 1;
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: predict on request accept, check on response accept
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      table_answer want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = predict_table(op_type'(req_op), req_key);
            answer_q.push_back(want);
            req_taken = 1'b1;
            req_accepts++;
         end
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               errors++;
               $display("%0t: response with none expected, expected nothing, %s",
                        $time, $sformatf("actual ok=%0b count=0x%0h",
                                         rsp_ok, rsp_result_count));
            end else begin
               want = answer_q.pop_front();
               check_field("ok",             want.ok,       rsp_ok);
               check_field("result_count",   want.count,    rsp_result_count);
               check_field("total_items",    want.total,    rsp_total_items);
               check_field("distinct_items", want.distinct, rsp_distinct_items);
               check_field("is_empty",       want.empty,    rsp_is_empty);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, answer_q.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------
   initial begin : run
      for (int i = 0; i < ENTRIES; i++) begin
         model_keys[i]   = '0;
         model_counts[i] = '0;
      end
      model_total = '0;
      model_live  = '0;

      // directed: lookups on an empty table
      add_request(OP_QUERY,     32'h0000_0000);
      add_request(OP_ERASE_ONE, 32'h0000_0000);
      add_request(OP_ERASE_ALL, 32'hFFFF_FFFF);
      // key extremes, a repeat insert and a one-bit neighbor
      add_request(OP_INSERT,    32'h0000_0000);
      add_request(OP_INSERT,    32'hFFFF_FFFF);
      add_request(OP_INSERT,    32'hFFFF_FFFF);
      add_request(OP_INSERT,    32'hFFFF_FFFE);
      add_request(OP_QUERY,     32'hFFFF_FFFF);
      // count down to zero; the stale key must no longer match
      add_request(OP_ERASE_ONE, 32'hFFFF_FFFF);
      add_request(OP_QUERY,     32'hFFFF_FFFF);
      add_request(OP_ERASE_ONE, 32'hFFFF_FFFF);
      add_request(OP_QUERY,     32'hFFFF_FFFF);
      // the freed entry is the lowest free one and gets reused
      add_request(OP_INSERT,    32'h8000_0000);
      add_request(OP_INSERT,    32'h0000_0001);
      add_request(OP_INSERT,    32'h0000_0001);
      add_request(OP_INSERT,    32'h0000_0001);
      add_request(OP_ERASE_ALL, 32'h0000_0001);
      add_request(OP_ERASE_ALL, 32'h0000_0001);
      add_request(OP_ERASE_ONE, 32'h0000_0000);
      add_request(OP_INSERT,    32'h7FFF_FFFF);
      add_request(OP_QUERY,     32'h8000_0000);
      // empty the table again
      add_request(OP_ERASE_ALL, 32'h8000_0000);
      add_request(OP_ERASE_ALL, 32'hFFFF_FFFE);
      add_request(OP_ERASE_ALL, 32'h7FFF_FFFF);
      add_request(OP_QUERY,     32'h0000_0000);

      repeat (3) build_round(100);

      total_requests = request_q.size();
      quiet_from     = total_requests - QUIET_ITEMS;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || req_valid) @(posedge clock);
      while (answer_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests in %0d cycles: %0d inserts refused on a full table,",
               total_requests, cycle_count, full_inserts);
      $display("%0d misses, peak of %0d live entries, %0d long receiver hold-offs, %0d mismatches",
               absent_lookups, peak_live, holds_done, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### counted_multiset_table_top.f
src/cmt_pkg.sv
src/cmt_ram.sv
src/cmt_scan.sv
src/counted_multiset_table_top.sv
verif/testbench.sv
